// ===== rtl/first_fit_block_allocator_assert.svh =====
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffba assertion failed");

// next-cycle implication
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffba assertion failed");

`endif

// ===== rtl/ffba_pkg.sv =====
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int HEAP_BYTES   = 65536;
    localparam int ADDR_SPACE   = 65536;
    localparam int LIMIT_CAP    = (HEAP_BYTES < ADDR_SPACE) ? HEAP_BYTES : ADDR_SPACE;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W  = 16;
    localparam int SIZE_W  = 16;
    localparam int BRK_W   = 17;
    localparam int END_W   = 18;
    localparam int ENTRY_W = ADDR_W + SIZE_W + 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_HEAP    = 3'd2,
        ST_FULL    = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    typedef struct packed {
        logic                command;
        logic [SIZE_W-1:0]   req_size;
        logic [ADDR_W-1:0]   block_addr;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   payload_addr;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   blk_start;
        logic [SIZE_W-1:0]   blk_size;
        logic                blk_free;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/ffba_ram.sv =====
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ffba_ctrl.sv =====
module ffba_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ffba_pkg::dp_sts_t sts,
    output ffba_pkg::dp_cmd_t cmd
);

    ffba_pkg::state_t state_reg;
    ffba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ffba_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ffba_pkg::S_SCAN;
                end
            end
            ffba_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ffba_pkg::S_COMMIT;
                end
            end
            ffba_pkg::S_COMMIT:
            begin
                cmd.commit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ffba_dp.sv =====
`include "first_fit_block_allocator_assert.svh"

module ffba_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ffba_pkg::in_item_t              in_data,
    output ffba_pkg::out_item_t             out_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            cfg_we,
    input  logic [ffba_pkg::BRK_W-1:0]      cfg_data,
    input  ffba_pkg::dp_cmd_t               cmd,
    output ffba_pkg::dp_sts_t               sts
);

    ffba_pkg::in_item_t                item_reg;
    logic [ffba_pkg::CNT_W-1:0]        issue_idx_reg;
    logic                              pend_reg;
    logic [ffba_pkg::IDX_W-1:0]        chk_idx_reg;
    logic                              found_reg;
    logic [ffba_pkg::IDX_W-1:0]        found_idx_reg;
    ffba_pkg::entry_t                  found_ent_reg;
    logic [ffba_pkg::BRK_W-1:0]        heap_limit_reg;
    logic [ffba_pkg::CNT_W-1:0]        block_count_reg;
    logic [ffba_pkg::CNT_W-1:0]        block_count_next;
    logic [ffba_pkg::BRK_W-1:0]        break_ptr_reg;
    logic [ffba_pkg::BRK_W-1:0]        break_ptr_next;
    logic                              out_valid_reg;
    ffba_pkg::out_item_t               out_reg;
    ffba_pkg::out_item_t               out_next;

    logic [ffba_pkg::ENTRY_W-1:0]      ram_rdata;
    ffba_pkg::entry_t                  rd_ent;
    logic                              ram_we;
    logic [ffba_pkg::IDX_W-1:0]        ram_waddr;
    ffba_pkg::entry_t                  ram_wdata;

    logic                              match;
    logic                              hit;
    logic                              more;
    logic                              out_free;
    logic                              is_null;
    logic [ffba_pkg::END_W-1:0]        end_val;
    logic [ffba_pkg::BRK_W-1:0]        eff_limit;
    logic                              heap_fail;
    logic                              table_full;
    logic                              is_last;
    logic                              append_c;

    ffba_ram #(
        .WIDTH (ffba_pkg::ENTRY_W),
        .DEPTH (ffba_pkg::MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_idx_reg[ffba_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // scan: one read issued per cycle, previous read compared
    assign rd_ent = ffba_pkg::entry_t'(ram_rdata);
    assign match  = (item_reg.command == ffba_pkg::CMD_FREE)
                  ? (rd_ent.blk_start == item_reg.block_addr)
                  : (rd_ent.blk_free && (rd_ent.blk_size >= item_reg.req_size));
    assign hit    = pend_reg && match;
    assign more   = issue_idx_reg < block_count_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign sts      = '{scan_done: hit || !more, out_free: out_free};

    // commit
    assign is_null   = (item_reg.command == ffba_pkg::CMD_FREE)
                     ? (item_reg.block_addr == '0) : (item_reg.req_size == '0);
    assign end_val   = ffba_pkg::END_W'(break_ptr_reg)
                     + ffba_pkg::END_W'(ffba_pkg::HEADER_BYTES)
                     + ffba_pkg::END_W'(item_reg.req_size);
    assign eff_limit = (heap_limit_reg > ffba_pkg::BRK_W'(ffba_pkg::LIMIT_CAP))
                     ? ffba_pkg::BRK_W'(ffba_pkg::LIMIT_CAP) : heap_limit_reg;
    assign heap_fail = end_val > ffba_pkg::END_W'(eff_limit);
    assign table_full = block_count_reg >= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS);
    assign is_last   = (ffba_pkg::CNT_W'(found_idx_reg) + ffba_pkg::CNT_W'(1))
                     == block_count_reg;
    assign append_c  = cmd.commit && !is_null && (item_reg.command == ffba_pkg::CMD_ALLOC)
                     && !found_reg && !heap_fail && !table_full;

    always_comb
    begin
        out_next         = '{status: ffba_pkg::ST_OK, payload_addr: '0};
        ram_we           = 1'b0;
        ram_waddr        = found_idx_reg;
        ram_wdata        = found_ent_reg;
        block_count_next = block_count_reg;
        break_ptr_next   = break_ptr_reg;
        priority if (is_null)
        begin
            out_next.status = ffba_pkg::ST_NULL;
        end
        else if (item_reg.command == ffba_pkg::CMD_FREE)
        begin
            if (!found_reg)
            begin
                out_next.status = ffba_pkg::ST_UNKNOWN;
            end
            else if (is_last)
            begin
                block_count_next = ffba_pkg::CNT_W'(found_idx_reg);
                break_ptr_next   =
                    (found_ent_reg.blk_start >= ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES))
                    ? ffba_pkg::BRK_W'(found_ent_reg.blk_start
                                       - ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES))
                    : '0;
            end
            else
            begin
                ram_we             = cmd.commit;
                ram_wdata.blk_free = 1'b1;
            end
        end
        else
        begin
            if (found_reg)
            begin
                ram_we                = cmd.commit;
                ram_wdata.blk_free    = 1'b0;
                out_next.payload_addr = found_ent_reg.blk_start;
            end
            else if (heap_fail)
            begin
                out_next.status = ffba_pkg::ST_HEAP;
            end
            else if (table_full)
            begin
                out_next.status = ffba_pkg::ST_FULL;
            end
            else
            begin
                ram_we              = cmd.commit;
                ram_waddr           = block_count_reg[ffba_pkg::IDX_W-1:0];
                ram_wdata.blk_start = ffba_pkg::ADDR_W'(break_ptr_reg
                                      + ffba_pkg::BRK_W'(ffba_pkg::HEADER_BYTES));
                ram_wdata.blk_size  = item_reg.req_size;
                ram_wdata.blk_free  = 1'b0;
                block_count_next    = block_count_reg + ffba_pkg::CNT_W'(1);
                break_ptr_next      = end_val[ffba_pkg::BRK_W-1:0];
                out_next.payload_addr = ram_wdata.blk_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg  <= ffba_pkg::BRK_W'(65536);
            block_count_reg <= '0;
            break_ptr_reg   <= '0;
            out_valid_reg   <= 1'b0;
            issue_idx_reg   <= '0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                heap_limit_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                issue_idx_reg <= '0;
                pend_reg      <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_reg  <= more && !hit;
                found_reg <= hit;
                if (more)
                begin
                    issue_idx_reg <= issue_idx_reg + ffba_pkg::CNT_W'(1);
                end
            end
            if (cmd.commit)
            begin
                block_count_reg <= block_count_next;
                break_ptr_reg   <= break_ptr_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.scan)
        begin
            chk_idx_reg   <= issue_idx_reg[ffba_pkg::IDX_W-1:0];
            found_idx_reg <= chk_idx_reg;
            found_ent_reg <= rd_ent;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `FFBA_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1,
        block_count_reg <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
    `FFBA_ASSERT_IMPLY(a_break_bound, clk, rst_n, 1'b1,
        break_ptr_reg <= ffba_pkg::BRK_W'(ffba_pkg::LIMIT_CAP))
    `FFBA_ASSERT_IMPLY(a_pend_in_table, clk, rst_n, pend_reg,
        ffba_pkg::CNT_W'(chk_idx_reg) < block_count_reg)
    `FFBA_ASSERT_NEXT(a_append_grows, clk, rst_n, append_c,
        block_count_reg == $past(block_count_reg) + ffba_pkg::CNT_W'(1))

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// First-fit block allocator. Each item on the input channel is an allocate
// or a free command and yields exactly one result item. With N blocks in
// the table (up to 64), a search that finds nothing reads all N entries,
// while a search that hits the entry at index k stops early. The table
// sits in a RAM with one write port and one registered read port, and the
// first-fit search or address lookup walks it one entry per cycle,
// followed by a commit that waits until the output register is free. One
// item is in work at a time; the next is taken as soon as the previous one
// has been committed to the output register, even if that result is not yet
// taken. The table needs no clearing after reset. The user must write
// heap_limit through cfg_we/cfg_data only while the block is idle; the
// block itself does not enforce this.
module first_fit_block_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ffba_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ffba_pkg::out_item_t         out_data,
    input  logic                        cfg_we,
    input  logic [ffba_pkg::BRK_W-1:0]  cfg_data
);

    ffba_pkg::dp_cmd_t cmd;
    ffba_pkg::dp_sts_t sts;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
